@@ rtl/core/paged_cache_slot_mapper_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the paged cache slot mapper
// Each macro checks one property on aclk, disabled while aresetn is low.
// Synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef PAGED_CACHE_SLOT_MAPPER_ASSERT_SVH
`define PAGED_CACHE_SLOT_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every edge out of reset
`define PCSM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("pcsm: assertion failed");

// Check that a condition is never seen out of reset
`define PCSM_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("pcsm: forbidden condition seen");

`else

`define PCSM_ASSERT(lbl, prop)
`define PCSM_ASSERT_NEVER(lbl, cond)

`endif

`endif

@@ rtl/core/pcsm_pkg.sv @@
// ----------------------------------------------------------------------------
// pcsm_pkg
// Shared constants, types and helpers of the paged cache slot mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package pcsm_pkg;

    // Sizes of the block
    localparam int TABLE_DEPTH      = 256;
    localparam int MAX_CHUNK        = 64;
    localparam int MAX_BATCH_TOKENS = 4096;
    localparam int NUM_PHYS_BLOCKS  = 65536;

    // Field widths
    localparam int TIDX_W  = 8;
    localparam int PHYS_W  = $clog2(NUM_PHYS_BLOCKS);
    localparam int POS_W   = 16;
    localparam int REM_W   = 16;
    localparam int BS_W    = 9;
    localparam int CS_W    = 7;
    localparam int SLOT_W  = 24;
    localparam int BPOS_W  = $clog2(MAX_BATCH_TOKENS);
    localparam int CNT_W   = $clog2(MAX_BATCH_TOKENS + 1);
    localparam int NTOK_W  = $clog2(MAX_CHUNK + 1);
    localparam int TADDR_W = $clog2(TABLE_DEPTH);
    // logical block index grows past the start quotient by up to a chunk
    localparam int BLK_W   = POS_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BS_W;

    localparam logic [BS_W-1:0] BS_MAX   = BS_W'(256);
    localparam logic [BS_W-1:0] BS_RESET = BS_W'(16);
    localparam logic [CS_W-1:0] CS_RESET = CS_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE = 1'b0,
        CFG_CHUNK_SIZE = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_TABLE_WRITE = 1'b0,
        OP_SEQUENCE    = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN
    } state_t;

    // Result of the start-position division
    typedef struct packed {
        logic              done;
        logic [POS_W-1:0]  quotient;
        logic [BS_W-1:0]   remainder;
    } div_res_t;

    // Map block size zero to one and cap it at 256
    function automatic logic [BS_W-1:0] bs_clamp(input logic [BS_W-1:0] v);
        logic [BS_W-1:0] r;
        if (v == '0) begin
            r = BS_W'(1);
        end else if (v > BS_MAX) begin
            r = BS_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Cap the chunk size at the largest chunk
    function automatic logic [CS_W-1:0] cs_clamp(input logic [CS_W-1:0] v);
        logic [CS_W-1:0] r;
        if (v > CS_W'(MAX_CHUNK)) begin
            r = CS_W'(MAX_CHUNK);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pcsm_table_ram.sv @@
// ----------------------------------------------------------------------------
// pcsm_table_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsm_table_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/pcsm_div.sv @@
// ----------------------------------------------------------------------------
// pcsm_div
// Shift-subtract divider: splits the start position into logical block and
// offset, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "paged_cache_slot_mapper_assert.svh"

module pcsm_div (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [pcsm_pkg::POS_W-1:0] dividend,
    input  wire logic [pcsm_pkg::BS_W-1:0]  divisor,
    output pcsm_pkg::div_res_t            res
);

    import pcsm_pkg::*;

    localparam int CNT_W = $clog2(POS_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [POS_W-1:0] quo_reg;
    logic [BS_W-1:0]  rem_reg;
    logic [BS_W-1:0]  dvs_reg;

    logic [BS_W:0]    trial;
    logic [BS_W:0]    diff;
    logic             ge;
    logic [BS_W-1:0]  rem_next;
    logic [POS_W-1:0] quo_next;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, quo_reg[POS_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = ge ? diff[BS_W-1:0] : trial[BS_W-1:0];
        quo_next = {quo_reg[POS_W-2:0], ge};
    end

    // Control: count the steps, pulse done after the last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(POS_W - 1);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= cnt_reg != '0;
            done_reg <= cnt_reg == '0;
        end else begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: dividend shifts out as the quotient shifts in
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

    `PCSM_ASSERT(a_div_start_busy, start |=> busy_reg)
    `PCSM_ASSERT(a_div_last_done, busy_reg && !start && (cnt_reg == '0) |=> done_reg && !busy_reg)
    `PCSM_ASSERT(a_div_rem_below, done_reg && (dvs_reg != '0) |-> rem_reg < dvs_reg)

endmodule

`default_nettype wire

@@ rtl/core/paged_cache_slot_mapper.sv @@
// ----------------------------------------------------------------------------
// paged_cache_slot_mapper
// Maps token positions of a sequence to physical slots of a paged KV cache.
// ----------------------------------------------------------------------------
// A table-write beat stores one physical block number.
// A sequence beat with tokens first splits its start position into logical
// block and offset in a shift-subtract divider, then streams one slot per
// cycle out of the block table RAM while the output is not stalled. The next
// beat is taken as soon as the last slot has left the table read stage,
// while that slot may still wait in the output register. A table write
// is held off until no slot reads the table.
// The table has no reset: entries must be written before they are used.
// ----------------------------------------------------------------------------
`default_nettype none
`include "paged_cache_slot_mapper_assert.svh"

module paged_cache_slot_mapper (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [pcsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pcsm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_opcode,
    input  wire logic                                s_first_of_batch,
    input  wire logic [pcsm_pkg::TIDX_W-1:0]         s_table_index,
    input  wire logic [pcsm_pkg::PHYS_W-1:0]         s_physical_block,
    input  wire logic                                s_decode_mode,
    input  wire logic [pcsm_pkg::POS_W-1:0]          s_computed_tokens,
    input  wire logic [pcsm_pkg::REM_W-1:0]          s_remaining_prefill,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [pcsm_pkg::SLOT_W-1:0]         m_slot,
    output logic      [pcsm_pkg::BPOS_W-1:0]         m_batch_position,
    output logic      [pcsm_pkg::CNT_W-1:0]          m_sequence_end,
    output logic                                     m_table_overflow,
    output logic                                     m_last
);

    import pcsm_pkg::*;

    localparam int MAC_W = PHYS_W + BS_W;

    // configuration registers
    logic [BS_W-1:0]   block_size_reg;
    logic [CS_W-1:0]   chunk_size_reg;
    logic [BS_W-1:0]   bs_eff;
    logic [CS_W-1:0]   cs_eff;

    // control
    state_t            state_reg;
    state_t            state_next;
    logic              s_fire;
    logic              seq_fire;
    logic              mem_we;
    logic              div_start;
    div_res_t          div_res;

    // batch accounting
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  base;
    logic [NTOK_W-1:0] n_item;
    logic [CNT_W:0]    sum;
    logic [CNT_W-1:0]  end_clamp;

    // slot generator
    logic [CNT_W-1:0]  start_reg;
    logic [CNT_W-1:0]  end_reg;
    logic [NTOK_W-1:0] n_reg;
    logic [NTOK_W-1:0] j_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [BS_W-1:0]   off_reg;
    logic [BS_W-1:0]   off_inc;
    logic              wrap;
    logic              last_tok;
    logic              gen_adv;
    logic [CNT_W:0]    bsum;
    logic [BPOS_W-1:0] bpos;

    // table read stage
    logic              b_valid_reg;
    logic [TADDR_W-1:0] b_addr_reg;
    logic [BS_W-1:0]   b_off_reg;
    logic              b_ovf_reg;
    logic [BPOS_W-1:0] b_bpos_reg;
    logic [CNT_W-1:0]  b_end_reg;
    logic              b_last_reg;
    logic              b_ready;
    logic              b_adv;
    logic [TADDR_W-1:0] rd_addr;
    logic [PHYS_W-1:0] tbl_rdata;
    logic [MAC_W-1:0]  mac;

    // output register
    logic              m_valid_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic [BPOS_W-1:0] m_bpos_reg;
    logic [CNT_W-1:0]  m_end_reg;
    logic              m_ovf_reg;
    logic              m_last_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= BS_RESET;
            chunk_size_reg <= CS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BLOCK_SIZE: block_size_reg <= cfg_wdata[BS_W-1:0];
                CFG_CHUNK_SIZE: chunk_size_reg <= cfg_wdata[CS_W-1:0];
                default: ;
            endcase
        end
    end

    assign bs_eff = bs_clamp(block_size_reg);
    assign cs_eff = cs_clamp(chunk_size_reg);

    assign s_fire   = s_valid && s_ready;
    assign seq_fire = s_fire && (s_opcode == OP_SEQUENCE);

    // Table writes past the table are dropped
    assign mem_we = s_fire && (s_opcode == OP_TABLE_WRITE) &&
                    (int'(s_table_index) < TABLE_DEPTH);

    // Token count and batch range of a sequence beat
    always_comb begin
        base = s_first_of_batch ? '0 : count_reg;
        if (s_decode_mode) begin
            n_item = NTOK_W'(1);
        end else if (s_remaining_prefill < REM_W'(cs_eff)) begin
            n_item = NTOK_W'(s_remaining_prefill);
        end else begin
            n_item = NTOK_W'(cs_eff);
        end
        sum = {1'b0, base} + (CNT_W + 1)'(n_item);
        if (sum > (CNT_W + 1)'(MAX_BATCH_TOKENS)) begin
            end_clamp = CNT_W'(MAX_BATCH_TOKENS);
        end else begin
            end_clamp = sum[CNT_W-1:0];
        end
    end

    // Batch token counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (seq_fire) begin
            count_reg <= (n_item != '0) ? end_clamp : base;
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (seq_fire && (n_item != '0)) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (gen_adv && last_tok) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs: take input only when idle and no slot still reads the table
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = !b_valid_reg;
                div_start = seq_fire && (n_item != '0);
            end
            ST_DIV: ;
            ST_RUN: ;
            default: ;
        endcase
    end

    pcsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_computed_tokens),
        .divisor  (bs_eff),
        .res      (div_res)
    );

    // Generator step: next offset, rolling into the next logical block
    always_comb begin
        off_inc  = off_reg + BS_W'(1);
        wrap     = off_inc == bs_eff;
        last_tok = (j_reg + NTOK_W'(1)) == n_reg;
        gen_adv  = (state_reg == ST_RUN) && b_adv;
        bsum     = {1'b0, start_reg} + (CNT_W + 1)'(j_reg);
        if (bsum > (CNT_W + 1)'(MAX_BATCH_TOKENS - 1)) begin
            bpos = BPOS_W'(MAX_BATCH_TOKENS - 1);
        end else begin
            bpos = bsum[BPOS_W-1:0];
        end
    end

    // Latch the item on acceptance
    always_ff @(posedge aclk) begin
        if (seq_fire) begin
            start_reg <= base;
            end_reg   <= end_clamp;
            n_reg     <= n_item;
        end
    end

    // Load block and offset from the divider, then advance per token
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_reg <= '0;
        end else if ((state_reg == ST_DIV) && div_res.done) begin
            j_reg <= '0;
        end else if (gen_adv) begin
            j_reg <= j_reg + NTOK_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DIV) && div_res.done) begin
            blk_reg <= BLK_W'(div_res.quotient);
            off_reg <= div_res.remainder;
        end else if (gen_adv) begin
            if (wrap) begin
                off_reg <= '0;
                blk_reg <= blk_reg + BLK_W'(1);
            end else begin
                off_reg <= off_inc;
            end
        end
    end

    // Table read stage: re-read the held address while stalled
    assign b_ready = !m_valid_reg || m_ready;
    assign b_adv   = !b_valid_reg || b_ready;
    assign rd_addr = gen_adv ? blk_reg[TADDR_W-1:0] : b_addr_reg;

    pcsm_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (PHYS_W)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (TADDR_W'(s_table_index)),
        .wdata (s_physical_block),
        .raddr (rd_addr),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_adv) begin
            b_valid_reg <= gen_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (gen_adv) begin
            b_addr_reg <= blk_reg[TADDR_W-1:0];
            b_off_reg  <= off_reg;
            b_ovf_reg  <= blk_reg >= BLK_W'(TABLE_DEPTH);
            b_bpos_reg <= bpos;
            b_end_reg  <= end_reg;
            b_last_reg <= last_tok;
        end
    end

    // Slot = physical block * block size + offset
    assign mac = ({{BS_W{1'b0}}, tbl_rdata} * {{PHYS_W{1'b0}}, bs_eff}) + MAC_W'(b_off_reg);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_ready) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg && b_ready) begin
            m_slot_reg <= b_ovf_reg ? '0 : mac[SLOT_W-1:0];
            m_bpos_reg <= b_bpos_reg;
            m_end_reg  <= b_end_reg;
            m_ovf_reg  <= b_ovf_reg;
            m_last_reg <= b_last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_slot           = m_slot_reg;
    assign m_batch_position = m_bpos_reg;
    assign m_sequence_end   = m_end_reg;
    assign m_table_overflow = m_ovf_reg;
    assign m_last           = m_last_reg;

    `PCSM_ASSERT(a_stall_rdata_held, b_valid_reg && !b_ready |=> $stable(tbl_rdata))
    `PCSM_ASSERT_NEVER(a_write_during_read, mem_we && b_valid_reg)
    `PCSM_ASSERT(a_last_token_idle, gen_adv && last_tok |=> state_reg == ST_IDLE)
    `PCSM_ASSERT(a_overflow_zero_slot, m_valid_reg && m_ovf_reg |-> m_slot_reg == '0)

endmodule

`default_nettype wire
